### rtl/nghri_pkg.sv
// ----------------------------------------------------------------------------
// N-gram hash row index package
// Shared constants, command codes and the queue entry carried from the
// front end to the back end.
// ----------------------------------------------------------------------------
package nghri_pkg;

   localparam int HEADS_PER_ORDER_DEF = 8;
   localparam int TOKEN_WIDTH_DEF     = 24;
   localparam int TOKEN_MAX           = 32;
   localparam int END_W               = 24;
   localparam int MULT_W              = 64;
   localparam int HEAD_W              = 4;
   localparam int TABLE_DEPTH         = 16;
   localparam int SIZE_W              = 32;
   localparam int ROW_W               = 33;
   localparam int QUEUE_DEPTH         = 2;
   localparam int CSR_ADDR_W          = 5;

   localparam logic [1:0] CMD_TOKEN = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] REG_MULT_CUR   = 2'd0;
   localparam logic [1:0] REG_MULT_PREV  = 2'd1;
   localparam logic [1:0] REG_MULT_PREV2 = 2'd2;
   localparam logic [1:0] REG_END_TOKEN  = 2'd3;

   typedef struct packed {
      logic                         is_write;
      logic [2:0][TOKEN_MAX-1:0]    ctx;
      logic [HEAD_W-1:0]            sel;
      logic [SIZE_W-1:0]            size;
      logic [SIZE_W-1:0]            offset;
   } entry_type;

   typedef struct packed {
      logic [MULT_W-1:0] cur;
      logic [MULT_W-1:0] prev;
      logic [MULT_W-1:0] prev2;
   } mults_type;

endpackage

### rtl/nghri_front.sv
// ----------------------------------------------------------------------------
// N-gram hash front end
// Accepts items, keeps the token history, builds the three-token context
// and pushes token and table-write work into the queue.
// ----------------------------------------------------------------------------
module nghri_front
   import nghri_pkg::*;
#(
   parameter int TOKEN_WIDTH = TOKEN_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [1:0]             command,
   input  logic [TOKEN_WIDTH-1:0] token_id,
   input  logic [HEAD_W-1:0]      head_sel,
   input  logic [SIZE_W-1:0]      head_size,
   input  logic [SIZE_W-1:0]      head_offset,
   input  logic [END_W-1:0]       end_token,
   input  logic                   q_full,
   output logic                   q_push,
   output entry_type              q_data
);

   logic [TOKEN_WIDTH-1:0] hist0_ff, hist0_in, hist1_ff, hist1_in;
   logic [1:0]             count_ff, count_in;
   logic [TOKEN_MAX-1:0]   end_ext, prev1, prev2, c1, c2;
   logic                   take;

   assign in_ready = !q_full;
   assign take     = in_valid && !q_full;
   assign end_ext  = TOKEN_MAX'(end_token);

   always_comb begin
      // missing history reads as the end token; an end token cuts older slots
      prev1 = (count_ff >= 2'd1) ? TOKEN_MAX'(hist0_ff) : end_ext;
      prev2 = (count_ff >= 2'd2) ? TOKEN_MAX'(hist1_ff) : end_ext;
      c1    = prev1;
      c2    = (c1 == end_ext) ? end_ext : prev2;

      q_data.is_write = (command == CMD_WRITE);
      q_data.ctx[0]   = TOKEN_MAX'(token_id);
      q_data.ctx[1]   = c1;
      q_data.ctx[2]   = c2;
      q_data.sel      = head_sel;
      q_data.size     = head_size;
      q_data.offset   = head_offset;
      q_push = take && (command == CMD_TOKEN || command == CMD_WRITE);

      hist0_in = hist0_ff;
      hist1_in = hist1_ff;
      count_in = count_ff;
      if (take && command == CMD_TOKEN) begin
         hist1_in = hist0_ff;
         hist0_in = token_id;
         if (count_ff < 2'd2) begin
            count_in = count_ff + 2'd1;
         end
      end else if (take && command == CMD_CLEAR) begin
         count_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      hist0_ff <= hist0_in;
      hist1_ff <= hist1_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

### rtl/nghri_queue.sv
// ----------------------------------------------------------------------------
// N-gram hash work queue
// Short FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module nghri_queue
   import nghri_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output logic      full,
   output logic      empty,
   output entry_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [PW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   assign full  = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + PW'(1);
      end
      if (pop) begin
         rp_in = (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/nghri_back.sv
// ----------------------------------------------------------------------------
// N-gram hash back end
// Holds the head table, forms the two hashes from 32x32 partial products
// and reduces them per head with a two-bit-per-cycle remainder unit.
// ----------------------------------------------------------------------------
module nghri_back
   import nghri_pkg::*;
#(
   parameter int HEADS_PER_ORDER = HEADS_PER_ORDER_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  entry_type          q_head,
   output logic               q_pop,
   input  mults_type          mults,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [HEAD_W-1:0]  out_head,
   output logic [ROW_W-1:0]   out_row,
   output logic               out_last
);

   localparam int TOTAL = 2 * HEADS_PER_ORDER;
   localparam int HCW   = (TOTAL > 1) ? $clog2(TOTAL) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [SIZE_W-1:0] size_tbl_ff [TABLE_DEPTH];
   logic [SIZE_W-1:0] off_tbl_ff  [TABLE_DEPTH];

   logic [2:0]               state_ff, state_in;
   logic [2:0][TOKEN_MAX-1:0] ctx_ff, ctx_in;
   logic [2:0]               step_ff, step_in;
   logic [2*SIZE_W-1:0]      pp_ff, pp_in, term_ff, term_in, term_sum;
   logic [MULT_W-1:0]        big_ff, big_in, tri_ff, tri_in;
   logic [HCW-1:0]           hcnt_ff, hcnt_in;
   logic [MULT_W-1:0]        q_ff, q_in;
   logic [SIZE_W-1:0]        rem_ff, rem_in, size_ff, size_in, off_ff, off_in;
   logic [4:0]               dcnt_ff, dcnt_in;
   logic                     ov_ff, ov_in, last_ff, last_in;
   logic [HEAD_W-1:0]        oh_ff, oh_in;
   logic [ROW_W-1:0]         orow_ff, orow_in;
   logic [SIZE_W-1:0]        mhalf;
   logic [MULT_W-1:0]        msel;
   logic [2:0]               pstep;
   logic [SIZE_W:0]          trial;
   logic [SIZE_W-1:0]        r;
   logic [MULT_W-1:0]        qs;
   logic [HEAD_W-1:0]        tidx;
   logic                     tbl_we;

   assign out_valid = ov_ff;
   assign out_head  = oh_ff;
   assign out_row   = orow_ff;
   assign out_last  = last_ff;
   assign tidx      = HEAD_W'(hcnt_ff);

   always_comb begin
      state_in = state_ff;
      ctx_in   = ctx_ff;
      step_in  = step_ff;
      pp_in    = pp_ff;
      term_in  = term_ff;
      big_in   = big_ff;
      tri_in   = tri_ff;
      hcnt_in  = hcnt_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      size_in  = size_ff;
      off_in   = off_ff;
      dcnt_in  = dcnt_ff;
      ov_in    = ov_ff && !out_ready;
      oh_in    = oh_ff;
      orow_in  = orow_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      tbl_we   = 1'b0;
      term_sum = term_ff + {pp_ff[SIZE_W-1:0], {SIZE_W{1'b0}}};
      pstep    = step_ff - 3'd1;
      trial    = '0;
      r        = rem_ff;
      qs       = q_ff;

      case (step_ff[2:1])
         2'd0:    msel = mults.cur;
         2'd1:    msel = mults.prev;
         default: msel = mults.prev2;
      endcase
      mhalf = step_ff[0] ? msel[MULT_W-1:SIZE_W] : msel[SIZE_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_head.is_write) begin
                  tbl_we = 1'b1;
               end else begin
                  ctx_in   = q_head.ctx;
                  step_in  = 3'd0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            // issue one partial product per cycle, fold the previous one in
            pp_in = {{SIZE_W{1'b0}}, mhalf} * {{SIZE_W{1'b0}}, ctx_ff[step_ff[2:1]]};
            if (step_ff != 3'd0) begin
               if (!pstep[0]) begin
                  term_in = pp_ff;
               end else begin
                  case (pstep[2:1])
                     2'd0:    big_in = term_sum;
                     2'd1:    big_in = big_ff ^ term_sum;
                     default: tri_in = big_ff ^ term_sum;
                  endcase
               end
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd6) begin
               hcnt_in  = '0;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            q_in     = (32'(hcnt_ff) < 32'(HEADS_PER_ORDER)) ? big_ff : tri_ff;
            rem_in   = '0;
            dcnt_in  = '0;
            size_in  = size_tbl_ff[tidx];
            off_in   = off_tbl_ff[tidx];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // two restoring steps per cycle
            for (int k = 0; k < 2; k++) begin
               trial = {r, qs[MULT_W-1]} - {1'b0, size_ff};
               if (!trial[SIZE_W]) begin
                  r = trial[SIZE_W-1:0];
               end else begin
                  r = {r[SIZE_W-2:0], qs[MULT_W-1]};
               end
               qs = {qs[MULT_W-2:0], 1'b0};
            end
            rem_in  = r;
            q_in    = qs;
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd31) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!ov_ff || out_ready) begin
               ov_in   = 1'b1;
               oh_in   = HEAD_W'(hcnt_ff);
               orow_in = ROW_W'((size_ff == '0) ? '0 : rem_ff) + ROW_W'(off_ff);
               last_in = (hcnt_ff == HCW'(TOTAL - 1));
               if (hcnt_ff == HCW'(TOTAL - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  hcnt_in  = hcnt_ff + HCW'(1);
                  state_in = ST_SETUP;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         size_tbl_ff[q_head.sel] <= q_head.size;
         off_tbl_ff[q_head.sel]  <= q_head.offset;
      end
      ctx_ff  <= ctx_in;
      step_ff <= step_in;
      pp_ff   <= pp_in;
      term_ff <= term_in;
      big_ff  <= big_in;
      tri_ff  <= tri_in;
      hcnt_ff <= hcnt_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      size_ff <= size_in;
      off_ff  <= off_in;
      dcnt_ff <= dcnt_in;
      oh_ff   <= oh_in;
      orow_ff <= orow_in;
      last_ff <= last_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
   end

endmodule

### rtl/ngram_hash_row_index_top.sv
// ----------------------------------------------------------------------------
// N-gram hash row index top level
// A token item is popped from the queue and hashed; for each head the back
// end loads the table entry, runs the two-bit-per-cycle remainder unit and
// emits the row, holding while the response is stalled. No new work is
// popped until the last head is out; table writes are done in the back end
// and clears never reach it. Synchronous active-high reset clears history,
// queue and output; the head table is undefined until written.
// ----------------------------------------------------------------------------
module ngram_hash_row_index_top
   import nghri_pkg::*;
#(
   parameter int HEADS_PER_ORDER = HEADS_PER_ORDER_DEF,
   parameter int TOKEN_WIDTH     = TOKEN_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_command,
   input  logic [TOKEN_WIDTH-1:0] req_token_id,
   input  logic [HEAD_W-1:0]      req_head_sel,
   input  logic [SIZE_W-1:0]      req_head_size,
   input  logic [SIZE_W-1:0]      req_head_offset,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [HEAD_W-1:0]      rsp_head_index,
   output logic [ROW_W-1:0]       rsp_row_index,
   output logic                   rsp_last_row,
   // configuration port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [MULT_W-1:0]      pwdata,
   output logic [MULT_W-1:0]      prdata,
   output logic                   pready
);

   mults_type        mults_ff, mults_in;
   logic [END_W-1:0] end_ff, end_in;
   logic             cfg_wr;
   logic             q_push, q_pop, q_full, q_empty;
   entry_type        q_wdata, q_head;

   // Registers sit at 8-byte strides; the index is paddr[4:3].
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      mults_in = mults_ff;
      end_in   = end_ff;
      if (cfg_wr) begin
         case (paddr[4:3])
            REG_MULT_CUR:   mults_in.cur   = pwdata;
            REG_MULT_PREV:  mults_in.prev  = pwdata;
            REG_MULT_PREV2: mults_in.prev2 = pwdata;
            REG_END_TOKEN:  end_in         = pwdata[END_W-1:0];
            default:        end_in         = end_ff;
         endcase
      end
      case (paddr[4:3])
         REG_MULT_CUR:   prdata = mults_ff.cur;
         REG_MULT_PREV:  prdata = mults_ff.prev;
         REG_MULT_PREV2: prdata = mults_ff.prev2;
         REG_END_TOKEN:  prdata = MULT_W'(end_ff);
         default:        prdata = '0;
      endcase
   end

   // Hold configuration; reset it to zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         mults_ff <= '0;
         end_ff   <= '0;
      end else begin
         mults_ff <= mults_in;
         end_ff   <= end_in;
      end
   end

   // Front end: take each transfer, resolve context, queue the work.
   nghri_front #(
      .TOKEN_WIDTH (TOKEN_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .command     (req_command),
      .token_id    (req_token_id),
      .head_sel    (req_head_sel),
      .head_size   (req_head_size),
      .head_offset (req_head_offset),
      .end_token   (end_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_wdata)
   );

   // Queue: lets the front keep taking transfers while the back end is busy, until it fills.
   nghri_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   // Back end: hash, reduce per head, drive the registered response.
   nghri_back #(
      .HEADS_PER_ORDER (HEADS_PER_ORDER)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .mults     (mults_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_head  (rsp_head_index),
      .out_row   (rsp_row_index),
      .out_last  (rsp_last_row)
   );

endmodule
